[src/whs_pkg.sv]
// ----------------------------------------------------------------------------
// whs_pkg
// Shared types, register indexes and mode codes of the wire hit selector.
// ----------------------------------------------------------------------------
`default_nettype none

package whs_pkg;

   // Field widths.
   localparam int ChanW   = 14;
   localparam int BinW    = 14;
   localparam int ChargeW = 16;
   localparam int RmsW    = 16;
   localparam int ThrW    = 20;
   localparam int WiresW  = 14;
   localparam int ModeW   = 3;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 20;

   // RMS threshold scale: 3.6 in Q8, and the width of the scaled RMS.
   localparam int RmsScale  = 922;
   localparam int RmsScaleW = 10;
   localparam int RmsThrW   = RmsW + RmsScaleW - 8;

   // Mode codes.
   localparam logic [ModeW-1:0] MODE_FIXED       = 3'd0;
   localparam logic [ModeW-1:0] MODE_RANGE       = 3'd1;
   localparam logic [ModeW-1:0] MODE_RMS         = 3'd2;
   localparam logic [ModeW-1:0] MODE_PLANE_NEIGH = 3'd3;
   localparam logic [ModeW-1:0] MODE_PLANE       = 3'd4;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] REG_MODE    = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_BASE    = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_THR_U   = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_THR_V   = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_THR_W   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_WIRES_U = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_WIRES_V = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_WIRES_W = 3'd7;

   // Plane codes.
   localparam logic [1:0] PLANE_U    = 2'd0;
   localparam logic [1:0] PLANE_V    = 2'd1;
   localparam logic [1:0] PLANE_W    = 2'd2;
   localparam logic [1:0] PLANE_NONE = 2'd3;

   // Configuration register file contents.
   typedef struct packed {
      logic [ModeW-1:0]  mode;
      logic [ThrW-1:0]   base_threshold;
      logic [ThrW-1:0]   plane_u_thr;
      logic [ThrW-1:0]   plane_v_thr;
      logic [ThrW-1:0]   plane_w_thr;
      logic [WiresW-1:0] wires_u;
      logic [WiresW-1:0] wires_v;
      logic [WiresW-1:0] wires_w;
   } csr_type;

   // Word after the window and plane classification stage.
   typedef struct packed {
      logic                      valid;
      logic [ChanW-1:0]          channel;
      logic [1:0]                plane_code;
      logic [1:0]                range_plane;
      logic                      first_bin;
      logic                      last_bin;
      logic signed [ChargeW-1:0] charge;
      logic signed [ChargeW-1:0] charge_before;
      logic signed [ChargeW-1:0] charge_after;
      logic signed [ChargeW-1:0] charge_alt;
      logic [RmsThrW-1:0]        rms_thr;
   } stage1_type;

   // Word after the threshold and neighbor selection stage.
   typedef struct packed {
      logic                      valid;
      logic                      neighbor;
      logic [ChanW-1:0]          channel;
      logic [ThrW-1:0]           thr;
      logic signed [ChargeW-1:0] charge;
      logic signed [ChargeW-1:0] charge_next;
      logic signed [ChargeW-1:0] charge_prev;
      logic signed [ChargeW-1:0] charge_alt;
      logic                      alt_next;
      logic                      alt_prev;
   } stage2_type;

endpackage

`default_nettype wire

[src/whs_csr.sv]
// ----------------------------------------------------------------------------
// whs_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_csr
   import whs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [CsrDatW-1:0] csr_write_data,
   output csr_type                 csr
);

   csr_type csr_ff;
   csr_type csr_in;

   // Each index updates its own register, truncated to the register width.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_MODE:    csr_in.mode           = csr_write_data[ModeW-1:0];
            REG_BASE:    csr_in.base_threshold = csr_write_data[ThrW-1:0];
            REG_THR_U:   csr_in.plane_u_thr    = csr_write_data[ThrW-1:0];
            REG_THR_V:   csr_in.plane_v_thr    = csr_write_data[ThrW-1:0];
            REG_THR_W:   csr_in.plane_w_thr    = csr_write_data[ThrW-1:0];
            REG_WIRES_U: csr_in.wires_u        = csr_write_data[WiresW-1:0];
            REG_WIRES_V: csr_in.wires_v        = csr_write_data[WiresW-1:0];
            REG_WIRES_W: csr_in.wires_w        = csr_write_data[WiresW-1:0];
            default:     csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

[src/whs_classify.sv]
// ----------------------------------------------------------------------------
// whs_classify
// First stage: trace window check, edge bins, plane by wire range and the
// scaled RMS threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_classify
   import whs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire csr_type                   csr,
   input  wire logic                      accept,
   input  wire logic [ChanW-1:0]          req_channel,
   input  wire logic [1:0]                req_plane_code,
   input  wire logic [BinW-1:0]           req_slice_bin,
   input  wire logic [BinW-1:0]           req_trace_start,
   input  wire logic [BinW-1:0]           req_trace_length,
   input  wire logic signed [ChargeW-1:0] req_charge,
   input  wire logic signed [ChargeW-1:0] req_charge_before,
   input  wire logic signed [ChargeW-1:0] req_charge_after,
   input  wire logic signed [ChargeW-1:0] req_charge_alt,
   input  wire logic [RmsW-1:0]           req_channel_rms,
   output stage1_type                     s1
);

   stage1_type s1_ff;
   stage1_type s1_in;

   logic [BinW:0]             trace_end;
   logic [BinW:0]             bin_plus_one;
   logic                      in_trace;
   logic [WiresW:0]           end_v;
   logic [WiresW+1:0]         end_w;
   logic [RmsW+RmsScaleW-1:0] rms_product;

   always_comb begin
      // Window: trace_start <= slice_bin < trace_start + trace_length.
      trace_end    = {1'b0, req_trace_start} + {1'b0, req_trace_length};
      bin_plus_one = {1'b0, req_slice_bin} + 1'b1;
      in_trace     = (req_slice_bin >= req_trace_start) &&
                     ({1'b0, req_slice_bin} < trace_end);

      // Plane boundaries from the wire counts.
      end_v = {1'b0, csr.wires_u} + {1'b0, csr.wires_v};
      end_w = {1'b0, end_v} + {2'b00, csr.wires_w};

      rms_product = req_channel_rms * RmsScaleW'(RmsScale);

      s1_in.valid         = accept && in_trace && (csr.mode <= MODE_PLANE);
      s1_in.channel       = req_channel;
      s1_in.plane_code    = req_plane_code;
      s1_in.first_bin     = (req_slice_bin == req_trace_start);
      s1_in.last_bin      = (bin_plus_one == trace_end);
      s1_in.charge        = req_charge;
      s1_in.charge_before = req_charge_before;
      s1_in.charge_after  = req_charge_after;
      s1_in.charge_alt    = req_charge_alt;
      s1_in.rms_thr       = rms_product[RmsW+RmsScaleW-1:8];

      if (req_channel < csr.wires_u) begin
         s1_in.range_plane = PLANE_U;
      end else if ({1'b0, req_channel} < end_v) begin
         s1_in.range_plane = PLANE_V;
      end else if ({2'b00, req_channel} < end_w) begin
         s1_in.range_plane = PLANE_W;
      end else begin
         s1_in.range_plane = PLANE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

`default_nettype wire

[src/whs_threshold.sv]
// ----------------------------------------------------------------------------
// whs_threshold
// Second stage: threshold selection by mode, neighbor selection at the trace
// edges and the alternate charge tests.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_threshold
   import whs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire csr_type    csr,
   input  wire stage1_type s1,
   output stage2_type      s2
);

   stage2_type s2_ff;
   stage2_type s2_in;

   logic [1:0]              plane_sel;
   logic [ThrW-1:0]         plane_thr;
   logic signed [ChargeW+1:0] alt_x3;

   always_comb begin
      // Range modes take the plane from wire counts, the others from geometry.
      if ((csr.mode == MODE_RANGE) || (csr.mode == MODE_RMS)) begin
         plane_sel = s1.range_plane;
      end else begin
         plane_sel = s1.plane_code;
      end

      case (plane_sel)
         PLANE_U: plane_thr = csr.plane_u_thr;
         PLANE_V: plane_thr = csr.plane_v_thr;
         PLANE_W: plane_thr = csr.plane_w_thr;
         default: plane_thr = csr.base_threshold;
      endcase

      s2_in.valid    = s1.valid;
      s2_in.channel  = s1.channel;
      s2_in.charge   = s1.charge;
      s2_in.charge_alt = s1.charge_alt;
      s2_in.neighbor = (csr.mode == MODE_RANGE) || (csr.mode == MODE_RMS) ||
                       (csr.mode == MODE_PLANE_NEIGH);

      // The RMS threshold applies in plane only, and only when nonzero.
      if (csr.mode == MODE_FIXED) begin
         s2_in.thr = csr.base_threshold;
      end else if ((csr.mode == MODE_RMS) && (s1.range_plane != PLANE_NONE) &&
                   (s1.rms_thr != '0)) begin
         s2_in.thr = ThrW'(s1.rms_thr);
      end else begin
         s2_in.thr = plane_thr;
      end

      // Edge bins mirror the one neighbor that exists.
      if (s1.first_bin) begin
         s2_in.charge_next = s1.charge_after;
         s2_in.charge_prev = s1.charge_after;
      end else if (s1.last_bin) begin
         s2_in.charge_next = s1.charge_before;
         s2_in.charge_prev = s1.charge_before;
      end else begin
         s2_in.charge_next = s1.charge_after;
         s2_in.charge_prev = s1.charge_before;
      end

      alt_x3 = (ChargeW+2)'(s1.charge_alt) + ((ChargeW+2)'(s1.charge_alt) <<< 1);
      s2_in.alt_next = alt_x3 > (ChargeW+2)'(s2_in.charge_next);
      s2_in.alt_prev = alt_x3 > (ChargeW+2)'(s2_in.charge_prev);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

`default_nettype wire

[src/whs_decide.sv]
// ----------------------------------------------------------------------------
// whs_decide
// Third stage: threshold compares, pass decision and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_decide
   import whs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire stage2_type                s2,
   output logic                           rsp_strobe,
   output logic [ChanW-1:0]               rsp_hit_channel,
   output logic signed [ChargeW-1:0]      rsp_hit_charge
);

   logic                      rsp_strobe_ff;
   logic                      rsp_strobe_in;
   logic [ChanW-1:0]          rsp_hit_channel_ff;
   logic signed [ChargeW-1:0] rsp_hit_charge_ff;
   logic                      over_self;
   logic                      over_next;
   logic                      over_prev;

   // A charge exceeds a Q4 threshold when sixteen times it is greater.
   function automatic logic above(input logic signed [ChargeW-1:0] q,
                                  input logic [ThrW-1:0] thr);
      logic signed [ChargeW+4:0] q16;
      logic signed [ChargeW+4:0] t;
      begin
         q16   = (ChargeW+5)'(q) <<< 4;
         t     = (ChargeW+5)'({1'b0, thr});
         above = q16 > t;
      end
   endfunction

   always_comb begin
      over_self = above(s2.charge, s2.thr);
      over_next = above(s2.charge_next, s2.thr);
      over_prev = above(s2.charge_prev, s2.thr);
      rsp_strobe_in = s2.valid &&
                      (over_self || (s2.neighbor &&
                       ((over_next && s2.alt_next) || (over_prev && s2.alt_prev))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Result payload; neighbor modes report the alternate charge.
   always_ff @(posedge clock) begin
      rsp_hit_channel_ff <= s2.channel;
      rsp_hit_charge_ff  <= s2.neighbor ? s2.charge_alt : s2.charge;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit_channel = rsp_hit_channel_ff;
   assign rsp_hit_charge  = rsp_hit_charge_ff;

endmodule

`default_nettype wire

[src/wire_hit_selector_unit.sv]
// ----------------------------------------------------------------------------
// wire_hit_selector_unit
// Selects wire hits: drops bins outside the trace, picks a threshold by mode
// and passes charges above it, or in neighbor modes near a neighbor above it.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Word
//   req       start / busy           channel, plane, bins, charges, rms
//   rsp       rsp_strobe (no stall)  hit_channel, hit_charge
//   csr       csr_write_enable       csr_index, csr_write_data
//
// A word is taken in every cycle; busy is always low. Its result, if any,
// shows on rsp after the three register stages (classify, threshold
// select, decide). Reset clears the stage valid bits, the result strobe and
// the configuration registers. The receiver cannot stall, so the pipeline
// never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module wire_hit_selector_unit
   import whs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [ChanW-1:0]          req_channel,
   input  wire logic [1:0]                req_plane_code,
   input  wire logic [BinW-1:0]           req_slice_bin,
   input  wire logic [BinW-1:0]           req_trace_start,
   input  wire logic [BinW-1:0]           req_trace_length,
   input  wire logic signed [ChargeW-1:0] req_charge,
   input  wire logic signed [ChargeW-1:0] req_charge_before,
   input  wire logic signed [ChargeW-1:0] req_charge_after,
   input  wire logic signed [ChargeW-1:0] req_charge_alt,
   input  wire logic [RmsW-1:0]           req_channel_rms,
   output logic                           rsp_strobe,
   output logic [ChanW-1:0]               rsp_hit_channel,
   output logic signed [ChargeW-1:0]      rsp_hit_charge,
   input  wire logic                      csr_write_enable,
   input  wire logic [CsrIdxW-1:0]        csr_index,
   input  wire logic [CsrDatW-1:0]        csr_write_data
);

   csr_type    csr;
   stage1_type s1;
   stage2_type s2;
   logic       accept;

   // The pipeline takes a word in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   whs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   whs_classify u_classify (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr),
      .accept            (accept),
      .req_channel       (req_channel),
      .req_plane_code    (req_plane_code),
      .req_slice_bin     (req_slice_bin),
      .req_trace_start   (req_trace_start),
      .req_trace_length  (req_trace_length),
      .req_charge        (req_charge),
      .req_charge_before (req_charge_before),
      .req_charge_after  (req_charge_after),
      .req_charge_alt    (req_charge_alt),
      .req_channel_rms   (req_channel_rms),
      .s1                (s1)
   );

   whs_threshold u_threshold (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .s1    (s1),
      .s2    (s2)
   );

   whs_decide u_decide (
      .clock           (clock),
      .reset           (reset),
      .s2              (s2),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit_channel (rsp_hit_channel),
      .rsp_hit_charge  (rsp_hit_charge)
   );

endmodule

`default_nettype wire

[tb/tb_wire_hit_selector_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wire_hit_selector_unit
// Self-checking bench for the wire hit selector. A short table of words goes
// first: window edges, field extremes, every mode and the unused modes.
// Random phases follow, each under a fresh register setting. Each accepted
// word without a typed outcome goes through a behavioral predictor, and each
// strobed hit is checked against the oldest expected hit.
// ----------------------------------------------------------------------------

module tb_wire_hit_selector_unit;
   import whs_pkg::*;

   // Pipeline depth of the block, and the idle-cycle watchdog limit.
   localparam int PIPE_DEPTH     = 3;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int NUM_PHASES     = 13;
   localparam int PHASE_WORDS    = 150;
   localparam int SPARE_WORDS    = 16;
   localparam int DIRECTED_ROWS  = 24;

   // Register setting styles for a phase.
   localparam int CFG_RANDOM  = 0;
   localparam int CFG_LOWEST  = 1;
   localparam int CFG_HIGHEST = 2;

   // Mode values the block does not define.
   localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ChanW-1:0]          channel;
      logic [1:0]                plane_code;
      logic [BinW-1:0]           slice_bin;
      logic [BinW-1:0]           trace_start;
      logic [BinW-1:0]           trace_length;
      logic signed [ChargeW-1:0] charge;
      logic signed [ChargeW-1:0] charge_before;
      logic signed [ChargeW-1:0] charge_after;
      logic signed [ChargeW-1:0] charge_alt;
      logic [RmsW-1:0]           channel_rms;
   } req_word_type;

   typedef struct packed {
      logic [ChanW-1:0]          channel;
      logic signed [ChargeW-1:0] charge;
   } hit_type;

   typedef struct {
      logic [ModeW-1:0] mode;
      req_word_type     word;
      bit               typed;
      bit               fires;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_word_type        req_w;
   logic                rsp_strobe;
   logic [ChanW-1:0]    rsp_hit_channel;
   logic signed [ChargeW-1:0] rsp_hit_charge;
   logic                csr_write_enable;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDatW-1:0]  csr_write_data;

   csr_type      cfg_shadow;
   hit_type      expected_hits[$];
   stim_row_type directed_rows[DIRECTED_ROWS];
   int           mismatch_count = 0;
   int           idle_cycles = 0;

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   wire_hit_selector_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_channel       (req_w.channel),
      .req_plane_code    (req_w.plane_code),
      .req_slice_bin     (req_w.slice_bin),
      .req_trace_start   (req_w.trace_start),
      .req_trace_length  (req_w.trace_length),
      .req_charge        (req_w.charge),
      .req_charge_before (req_w.charge_before),
      .req_charge_after  (req_w.charge_after),
      .req_charge_alt    (req_w.charge_alt),
      .req_channel_rms   (req_w.channel_rms),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit_channel   (rsp_hit_channel),
      .rsp_hit_charge    (rsp_hit_charge),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // A Q4 threshold is exceeded when sixteen times the charge is larger.
   function automatic bit exceeds(input int q, input int unsigned thr);
      return longint'(q) * 16 > longint'(thr);
   endfunction

   function automatic int unsigned plane_threshold(input int unsigned plane);
      case (plane)
         PLANE_U: return cfg_shadow.plane_u_thr;
         PLANE_V: return cfg_shadow.plane_v_thr;
         PLANE_W: return cfg_shadow.plane_w_thr;
         default: return cfg_shadow.base_threshold;
      endcase
   endfunction

   // Works out whether a word yields a hit under the current registers.
   function automatic bit predict_hit(input req_word_type w, output hit_type h);
      int unsigned sbin, tstart, tlen, offset, thr, plane, ch;
      int unsigned u_end, v_end, w_end, rms;
      int q, q_alt, q_next, q_prev;
      bit pass;
      sbin   = w.slice_bin;
      tstart = w.trace_start;
      tlen   = w.trace_length;
      ch     = w.channel;
      rms    = w.channel_rms;
      q      = w.charge;
      q_alt  = w.charge_alt;
      h.channel = w.channel;
      h.charge  = w.charge;
      if (cfg_shadow.mode > MODE_PLANE) return 1'b0;
      if (sbin < tstart || sbin >= tstart + tlen) return 1'b0;
      offset = sbin - tstart;

      // Plane from the consecutive wire ranges.
      u_end = cfg_shadow.wires_u;
      v_end = u_end + cfg_shadow.wires_v;
      w_end = v_end + cfg_shadow.wires_w;
      if (ch < u_end) plane = PLANE_U;
      else if (ch < v_end) plane = PLANE_V;
      else if (ch < w_end) plane = PLANE_W;
      else plane = PLANE_NONE;

      case (cfg_shadow.mode)
         MODE_FIXED: thr = cfg_shadow.base_threshold;
         MODE_RANGE: thr = plane_threshold(plane);
         MODE_RMS: begin
            if (plane == PLANE_NONE) begin
               thr = cfg_shadow.base_threshold;
            end else begin
               thr = (rms * RmsScale) >> 8;
               if (thr == 0) thr = plane_threshold(plane);
            end
         end
         default: thr = plane_threshold(w.plane_code);
      endcase

      if (cfg_shadow.mode == MODE_FIXED || cfg_shadow.mode == MODE_PLANE) begin
         return exceeds(q, thr);
      end

      // Neighbor modes: edge bins mirror the one neighbor they have.
      if (offset == 0) begin
         q_next = w.charge_after;
         q_prev = w.charge_after;
      end else if (offset == tlen - 1) begin
         q_next = w.charge_before;
         q_prev = w.charge_before;
      end else begin
         q_next = w.charge_after;
         q_prev = w.charge_before;
      end
      pass = exceeds(q, thr) ||
             (exceeds(q_next, thr) && longint'(q_alt) * 3 > longint'(q_next)) ||
             (exceeds(q_prev, thr) && longint'(q_alt) * 3 > longint'(q_prev));
      h.charge = w.charge_alt;
      return pass;
   endfunction

   function automatic stim_row_type stim_row(input logic [ModeW-1:0] mode, input int ch,
                                             input int pc, input int sbin, input int ts,
                                             input int tl, input int q, input int qb,
                                             input int qa, input int q_alt, input int rms,
                                             input bit typed, input bit fires);
      stim_row_type r;
      r.mode                    = mode;
      r.word.channel            = ChanW'(ch);
      r.word.plane_code         = 2'(pc);
      r.word.slice_bin          = BinW'(sbin);
      r.word.trace_start        = BinW'(ts);
      r.word.trace_length       = BinW'(tl);
      r.word.charge             = ChargeW'(q);
      r.word.charge_before      = ChargeW'(qb);
      r.word.charge_after       = ChargeW'(qa);
      r.word.charge_alt         = ChargeW'(q_alt);
      r.word.channel_rms        = RmsW'(rms);
      r.typed                   = typed;
      r.fires                   = fires;
      return r;
   endfunction

   // Charges cluster around typical thresholds, with some full-range values.
   function automatic logic signed [ChargeW-1:0] pick_charge();
      if ($urandom_range(0, 99) < 15) return ChargeW'($urandom_range(0, 65535));
      return ChargeW'(int'($urandom_range(0, 700)) - 200);
   endfunction

   function automatic logic [RmsW-1:0] pick_rms();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return RmsW'($urandom_range(0, 65535));
         default: return RmsW'($urandom_range(0, 2000));
      endcase
   endfunction

   function automatic logic [ThrW-1:0] pick_threshold(input int style);
      if (style == CFG_LOWEST) return '0;
      if (style == CFG_HIGHEST) return '1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return ThrW'($urandom_range(0, 8000));
      endcase
   endfunction

   function automatic logic [WiresW-1:0] pick_wires(input int style);
      if (style == CFG_LOWEST) return '0;
      if (style == CFG_HIGHEST) return '1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return WiresW'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic logic [ModeW-1:0] mode_of_phase(input int p);
      case (p % 5)
         0: return MODE_FIXED;
         1: return MODE_RANGE;
         2: return MODE_RMS;
         3: return MODE_PLANE_NEIGH;
         default: return MODE_PLANE;
      endcase
   endfunction

   // Mostly bins inside a short trace, weighted toward its edges; some noise.
   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned span, len, first_bin, offset;
      w.plane_code    = 2'($urandom_range(0, 3));
      w.charge        = pick_charge();
      w.charge_before = pick_charge();
      w.charge_after  = pick_charge();
      w.charge_alt    = pick_charge();
      w.channel_rms   = pick_rms();
      if ($urandom_range(0, 99) < 12) begin
         w.channel      = ChanW'($urandom_range(0, 16383));
         w.slice_bin    = BinW'($urandom_range(0, 16383));
         w.trace_start  = BinW'($urandom_range(0, 16383));
         w.trace_length = BinW'($urandom_range(0, 16383));
         return w;
      end
      span = int'(cfg_shadow.wires_u) + int'(cfg_shadow.wires_v) + int'(cfg_shadow.wires_w);
      if ($urandom_range(0, 9) == 0 || span > 16363) begin
         w.channel = ChanW'($urandom_range(0, 16383));
      end else begin
         w.channel = ChanW'($urandom_range(0, span + 20));
      end
      case ($urandom_range(0, 9))
         0: len = 1;
         1: len = $urandom_range(9, 64);
         default: len = $urandom_range(2, 8);
      endcase
      first_bin      = $urandom_range(0, 16383 - len);
      w.trace_start  = BinW'(first_bin);
      w.trace_length = BinW'(len);
      case ($urandom_range(0, 9))
         0, 1, 2: offset = 0;
         3, 4, 5: offset = len - 1;
         6: offset = len;
         default: offset = $urandom_range(0, len - 1);
      endcase
      if (offset == len && first_bin > 0 && $urandom_range(0, 1) == 1) begin
         w.slice_bin = BinW'(first_bin - 1);
      end else begin
         w.slice_bin = BinW'(first_bin + offset);
      end
      return w;
   endfunction

   // Writes one register and mirrors it into the shadow copy.
   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_MODE:    cfg_shadow.mode           = data[ModeW-1:0];
         REG_BASE:    cfg_shadow.base_threshold = data[ThrW-1:0];
         REG_THR_U:   cfg_shadow.plane_u_thr    = data[ThrW-1:0];
         REG_THR_V:   cfg_shadow.plane_v_thr    = data[ThrW-1:0];
         REG_THR_W:   cfg_shadow.plane_w_thr    = data[ThrW-1:0];
         REG_WIRES_U: cfg_shadow.wires_u        = data[WiresW-1:0];
         REG_WIRES_V: cfg_shadow.wires_v        = data[WiresW-1:0];
         REG_WIRES_W: cfg_shadow.wires_w        = data[WiresW-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Stops issuing words and lets the pipeline empty, including words that
   // produce no hit.
   task automatic settle_pipe();
      start <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic program_phase(input logic [ModeW-1:0] mode, input int style);
      settle_pipe();
      write_csr(REG_BASE, CsrDatW'(pick_threshold(style)));
      write_csr(REG_THR_U, CsrDatW'(pick_threshold(style)));
      write_csr(REG_THR_V, CsrDatW'(pick_threshold(style)));
      write_csr(REG_THR_W, CsrDatW'(pick_threshold(style)));
      write_csr(REG_WIRES_U, CsrDatW'(pick_wires(style)));
      write_csr(REG_WIRES_V, CsrDatW'(pick_wires(style)));
      write_csr(REG_WIRES_W, CsrDatW'(pick_wires(style)));
      write_csr(REG_MODE, CsrDatW'(mode));
      csr_write_enable <= 1'b0;
   endtask

   // Offers one word after a gap, and records its hit once it is taken.
   task automatic drive_word(input req_word_type w, input int unsigned gap, input bit typed,
                             input bit typed_fires);
      hit_type h;
      bit      fire;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_w <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (typed) begin
         fire      = typed_fires;
         h.channel = w.channel;
         h.charge  = w.charge;
      end else begin
         fire = predict_hit(w, h);
      end
      if (fire) expected_hits.insert(expected_hits.size(), h);
      @(negedge clock);
   endtask

   // Result checker: each strobed hit against the oldest expected one.
   always @(posedge clock) begin
      hit_type due;
      if (!reset && rsp_strobe) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected hit, expected none, channel %0d charge %0d", $time,
                     rsp_hit_channel, rsp_hit_charge);
            mismatch_count++;
         end else begin
            due = expected_hits.pop_front();
            if (rsp_hit_channel !== due.channel) begin
               $display("%0t: hit_channel expected %0d actual %0d", $time,
                        due.channel, rsp_hit_channel);
               mismatch_count++;
            end
            if (rsp_hit_charge !== due.charge) begin
               $display("%0t: hit_charge expected %0d actual %0d", $time,
                        due.charge, rsp_hit_charge);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither a word nor a hit is taken.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_w            = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_MODE;
      csr_write_data   = '0;
      cfg_shadow       = '0;

      // Directed table. Thresholds: base 16, u 10, v 20, w 30 counts;
      // 100 wires per plane. Typed rows carry their expected outcome.
      directed_rows[0]  = stim_row(MODE_FIXED, 5, PLANE_U, 10, 10, 5, 17, 0, 0, 0, 0, 1, 1);
      directed_rows[1]  = stim_row(MODE_FIXED, 5, PLANE_U, 12, 10, 5, 16, 0, 0, 0, 0, 1, 0);
      directed_rows[2]  = stim_row(MODE_FIXED, 5, PLANE_U, 9, 10, 5, 1000, 0, 0, 0, 0, 1, 0);
      directed_rows[3]  = stim_row(MODE_FIXED, 5, PLANE_U, 15, 10, 5, 1000, 0, 0, 0, 0, 1, 0);
      directed_rows[4]  = stim_row(MODE_FIXED, 5, PLANE_U, 10, 10, 0, 1000, 0, 0, 0, 0, 1, 0);
      directed_rows[5]  = stim_row(MODE_FIXED, 16383, PLANE_NONE, 16383, 16383, 1, 32767,
                                   -1, -1, -1, 65535, 1, 1);
      directed_rows[6]  = stim_row(MODE_FIXED, 0, PLANE_U, 0, 0, 16383, -32768,
                                   -32768, -32768, -32768, 0, 1, 0);
      directed_rows[7]  = stim_row(MODE_PLANE, 7, PLANE_U, 100, 90, 20, 11, 0, 0, 0, 0, 0, 0);
      directed_rows[8]  = stim_row(MODE_PLANE, 7, PLANE_NONE, 100, 90, 20, 17, 0, 0, 0, 0, 0, 0);
      directed_rows[9]  = stim_row(MODE_PLANE, 7, PLANE_W, 100, 90, 20, 30, 0, 0, 0, 0, 0, 0);
      directed_rows[10] = stim_row(MODE_RANGE, 50, PLANE_NONE, 100, 90, 20, 11, 0, 0, -5, 0, 0, 0);
      directed_rows[11] = stim_row(MODE_RANGE, 150, PLANE_U, 90, 90, 20, 0, 500, 21, 8, 0, 0, 0);
      directed_rows[12] = stim_row(MODE_RANGE, 250, PLANE_V, 109, 90, 20, 0, 31, 500, 10, 0, 0, 0);
      directed_rows[13] = stim_row(MODE_RANGE, 300, PLANE_W, 100, 90, 20, 0, 17, 0, 6, 0, 0, 0);
      directed_rows[14] = stim_row(MODE_RANGE, 150, PLANE_U, 40, 40, 1, 0, 100, 21, 8, 0, 0, 0);
      directed_rows[15] = stim_row(MODE_RMS, 10, PLANE_U, 100, 90, 20, 226, 0, 0, 1, 1000, 0, 0);
      directed_rows[16] = stim_row(MODE_RMS, 10, PLANE_U, 100, 90, 20, 11, 0, 0, 2, 0, 0, 0);
      directed_rows[17] = stim_row(MODE_RMS, 10, PLANE_U, 100, 90, 20, 32767, 0, 0, 3,
                                   65535, 0, 0);
      directed_rows[18] = stim_row(MODE_RMS, 10, PLANE_U, 100, 90, 20, 14751, 0, 0, 4,
                                   65535, 0, 0);
      directed_rows[19] = stim_row(MODE_RMS, 16383, PLANE_U, 100, 90, 20, 17, 0, 0, 5,
                                   1000, 0, 0);
      directed_rows[20] = stim_row(MODE_PLANE_NEIGH, 7, PLANE_V, 100, 90, 20, 0, 0, 21, 8,
                                   0, 0, 0);
      directed_rows[21] = stim_row(MODE_PLANE_NEIGH, 7, PLANE_NONE, 100, 90, 20, 17, 0, 0,
                                   -32768, 0, 0, 0);
      directed_rows[22] = stim_row(MODE_SPARE_LO, 5, PLANE_U, 10, 10, 5, 32767, 0, 0, 0, 0, 1, 0);
      directed_rows[23] = stim_row(MODE_SPARE_HI, 5, PLANE_U, 10, 10, 5, 32767, 0, 0, 0, 0, 1, 0);

      // Synchronous reset, then release.
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fixed register setting for the directed words.
      write_csr(REG_BASE, CsrDatW'(256));
      write_csr(REG_THR_U, CsrDatW'(160));
      write_csr(REG_THR_V, CsrDatW'(320));
      write_csr(REG_THR_W, CsrDatW'(480));
      write_csr(REG_WIRES_U, CsrDatW'(100));
      write_csr(REG_WIRES_V, CsrDatW'(100));
      write_csr(REG_WIRES_W, CsrDatW'(100));
      csr_write_enable <= 1'b0;

      // Directed words; the mode changes only with the pipeline empty.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != cfg_shadow.mode) begin
            settle_pipe();
            write_csr(REG_MODE, CsrDatW'(directed_rows[i].mode));
            csr_write_enable <= 1'b0;
         end
         drive_word(directed_rows[i].word, $urandom_range(0, 18), directed_rows[i].typed,
                    directed_rows[i].fires);
      end

      // Random phases, each with its own registers; every third runs back to back.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 7) program_phase(mode_of_phase(p), CFG_LOWEST);
         else if (p == 8 || p == 11) program_phase(mode_of_phase(p), CFG_HIGHEST);
         else program_phase(mode_of_phase(p), CFG_RANDOM);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            drive_word(random_word(), (p % 3 == 0) ? 0 : $urandom_range(0, 18), 1'b0, 1'b0);
         end
      end

      // Short runs in the unused modes, where no word may produce a hit.
      program_phase(MODE_SPARE_LO, CFG_RANDOM);
      for (int n = 0; n < SPARE_WORDS; n++) begin
         drive_word(random_word(), $urandom_range(0, 18), 1'b0, 1'b0);
      end
      program_phase(MODE_SPARE_HI, CFG_RANDOM);
      for (int n = 0; n < SPARE_WORDS; n++) begin
         drive_word(random_word(), $urandom_range(0, 18), 1'b0, 1'b0);
      end

      // Drain, then keep watching for stray hits before the verdict.
      start <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
src/whs_pkg.sv
src/whs_csr.sv
src/whs_classify.sv
src/whs_threshold.sv
src/whs_decide.sv
src/wire_hit_selector_unit.sv
tb/tb_wire_hit_selector_unit.sv
